// ===== hw/rtl/bq_pkg.sv =====
// Shared types and constants for the Q15 biquad low-pass filter.
// No dependencies; imported by the register block, the filter core and the top level.
`default_nettype none

package bq_pkg;

    localparam int SampleW = 11;   // converter sample and filtered result
    localparam int DataW   = 16;   // Q15 words: coefficients, inputs, outputs
    localparam int ProdW   = 2 * DataW;
    localparam int AccW    = ProdW + 3;  // headroom for five products
    localparam int FracW   = 15;
    localparam int InShift = 5;    // sample * 32
    localparam int OutShift = 5;   // stored output >>> 5
    localparam int AddrW   = 5;
    localparam int PDataW  = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] RegFf0 = 3'd0;
    localparam logic [2:0] RegFf1 = 3'd1;
    localparam logic [2:0] RegFf2 = 3'd2;
    localparam logic [2:0] RegFb1 = 3'd3;
    localparam logic [2:0] RegFb2 = 3'd4;

    typedef logic signed [DataW-1:0] t_q15;

    typedef struct packed {
        t_q15 ff0;
        t_q15 ff1;
        t_q15 ff2;
        t_q15 fb1;
        t_q15 fb2;
    } t_coefs;

endpackage

`default_nettype wire

// ===== hw/rtl/biquad_q15_lowpass_unit.sv =====
// Top level of the Q15 biquad low-pass filter.
// Depends on bq_pkg, bq_cfg_regs and bq_core.
`default_nettype none

// Second-order Direct Form I IIR filter. Each 11-bit signed sample is scaled
// by 32 into Q15, filtered with five coefficients from the APB registers
// (ff0/ff1/ff2 at 0x00/0x04/0x08, fb1/fb2 at 0x0C/0x10, 16-bit signed, reset
// to zero), rounded and wrapped to 16 bits, and returned shifted right by 5.
// Throughput is one sample per clock while results are taken; a stalled
// result register holds the input back. A sample passes the input register,
// then the result register, around the combinational multiply-accumulate,
// which also closes the feedback loop through the previous outputs. Write
// coefficients only while no sample is in flight.
module biquad_q15_lowpass_unit
    import bq_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [AddrW-1:0]           paddr,
    input  wire logic [PDataW-1:0]          pwdata,
    output logic      [PDataW-1:0]          prdata,
    output logic                            pready,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic signed [SampleW-1:0]  i_sample,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic signed [SampleW-1:0]       o_filtered
);

    t_coefs coefs;

    bq_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coefs (coefs)
    );

    bq_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_coefs     (coefs),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_filtered  (o_filtered)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/bq_cfg_regs.sv =====
// APB-style coefficient register file for the biquad filter.
// Depends on bq_pkg for the register indexes and the coefficient struct.
`default_nettype none

module bq_cfg_regs
    import bq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [AddrW-1:0]  paddr,
    input  wire logic [PDataW-1:0] pwdata,
    output logic      [PDataW-1:0] prdata,
    output logic                   pready,
    output t_coefs                 o_coefs
);

    t_coefs     r_coefs;
    logic       wr_en;
    logic [2:0] reg_idx;
    t_q15       rd_val;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[AddrW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                RegFf0:  r_coefs.ff0 <= pwdata[DataW-1:0];
                RegFf1:  r_coefs.ff1 <= pwdata[DataW-1:0];
                RegFf2:  r_coefs.ff2 <= pwdata[DataW-1:0];
                RegFb1:  r_coefs.fb1 <= pwdata[DataW-1:0];
                RegFb2:  r_coefs.fb2 <= pwdata[DataW-1:0];
                default: ; // drop writes past the last register
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            RegFf0:  rd_val = r_coefs.ff0;
            RegFf1:  rd_val = r_coefs.ff1;
            RegFf2:  rd_val = r_coefs.ff2;
            RegFb1:  rd_val = r_coefs.fb1;
            RegFb2:  rd_val = r_coefs.fb2;
            default: rd_val = '0;
        endcase
    end

    assign prdata  = {{(PDataW-DataW){rd_val[DataW-1]}}, rd_val};
    assign o_coefs = r_coefs;

endmodule

`default_nettype wire

// ===== hw/rtl/bq_core.sv =====
// Direct Form I biquad datapath: input register, five Q15 products, rounding,
// history registers and result register. Depends on bq_pkg.
`default_nettype none

module bq_core
    import bq_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_coefs                     i_coefs,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic signed [SampleW-1:0]  i_sample,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic signed [SampleW-1:0]       o_filtered
);

    logic                      r_in_valid;
    t_q15                      r_x;
    logic                      r_out_valid;
    logic signed [SampleW-1:0] r_filtered;
    t_q15                      r_x1, r_x2, r_y1, r_y2;

    logic                      advance;
    logic                      in_xfer;
    t_q15                      n_x;
    logic signed [ProdW-1:0]   p0, p1, p2, p3, p4;
    logic [AccW-1:0]           acc;
    logic [AccW-1:0]           rounded;
    t_q15                      n_y;

    // The core moves an item forward when the result register is free or drains.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign n_x        = {i_sample, {InShift{1'b0}}};

    assign p0 = i_coefs.ff0 * r_x;
    assign p1 = i_coefs.ff1 * r_x1;
    assign p2 = i_coefs.ff2 * r_x2;
    assign p3 = i_coefs.fb1 * r_y1;
    assign p4 = i_coefs.fb2 * r_y2;

    assign acc = {{(AccW-ProdW){p0[ProdW-1]}}, p0}
               + {{(AccW-ProdW){p1[ProdW-1]}}, p1}
               + {{(AccW-ProdW){p2[ProdW-1]}}, p2}
               - {{(AccW-ProdW){p3[ProdW-1]}}, p3}
               - {{(AccW-ProdW){p4[ProdW-1]}}, p4};

    // Round half up, shift by 15, keep the low 16 bits (wraps)
    assign rounded = acc + (AccW'(1) << (FracW - 1));
    assign n_y     = rounded[FracW+DataW-1:FracW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_x1        <= '0;
            r_x2        <= '0;
            r_y1        <= '0;
            r_y2        <= '0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (advance) begin
                r_x2 <= r_x1;
                r_x1 <= r_x;
                r_y2 <= r_y1;
                r_y1 <= n_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_x <= n_x;
        end
        if (advance) begin
            r_filtered <= n_y[DataW-1:OutShift];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_filtered;

endmodule

`default_nettype wire
